[hdl/rtlfm_pkg.sv]
// Shared types and constants for the round-trip latency and frame-rate monitor.
`default_nettype none
package rtlfm_pkg;

  // Ring and table sizes, given as powers of two
  localparam int FPS_HIST_LOG2 = 4;
  localparam int LAT_HIST_LOG2 = 4;
  localparam int PEND_LOG2     = 6;

  localparam int FPS_HISTORY     = 1 << FPS_HIST_LOG2;
  localparam int LATENCY_HISTORY = 1 << LAT_HIST_LOG2;
  localparam int PENDING_DEPTH   = 1 << PEND_LOG2;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int FRAME_W = 32;
  localparam int FPS_W   = 10;
  localparam int LAT_W   = 16;

  // Running sums are wide enough for a full ring of maximum values
  localparam int FPS_SUM_W = FPS_W + FPS_HIST_LOG2;
  localparam int LAT_SUM_W = LAT_W + LAT_HIST_LOG2;
  localparam int SUM_W     = (FPS_SUM_W > LAT_SUM_W) ? FPS_SUM_W : LAT_SUM_W;

  // Post-reset clear pass covers the deepest store
  localparam int CLR_LOG2 = (PEND_LOG2 > FPS_HIST_LOG2) ?
                            ((PEND_LOG2 > LAT_HIST_LOG2) ? PEND_LOG2 : LAT_HIST_LOG2) :
                            ((FPS_HIST_LOG2 > LAT_HIST_LOG2) ? FPS_HIST_LOG2 : LAT_HIST_LOG2);
  localparam int CLEAR_DEPTH = 1 << CLR_LOG2;

  // Behavior constants
  localparam int FPS_INTERVAL_MS  = 1000;
  localparam int FPS_RESET        = 30;
  localparam int LATENCY_RESET_MS = 200;

  // Event codes
  localparam logic OP_FRAME_START = 1'b0;
  localparam logic OP_RESPONSE    = 1'b1;

  // Request into the shared add/subtract unit
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

endpackage
`default_nettype wire

[hdl/round_trip_latency_fps_monitor.sv]
// Top level of the round-trip latency and frame-rate monitor.
// After reset the block walks all CLEAR_DEPTH addresses (64 by default), loading
// the send-stamp table and both rings with their starting values; busy is high
// throughout. An event is taken when start is high and busy is low. Every
// event then goes through the registered table and ring reads, then three
// passes through the single shared adder (time difference, remove the old
// ring entry from the sum, add the new one). Its one result shows on the
// output ports with done high for exactly one cycle, and busy drops in that
// same cycle, so a new event can start there. The receiver cannot stall the
// block: a result not captured in its done cycle is overwritten by the next.
`default_nettype none
module round_trip_latency_fps_monitor (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  opcode,
  input  wire  [rtlfm_pkg::FRAME_W-1:0]        frame_number,
  input  wire  [rtlfm_pkg::TIME_W-1:0]         now_ms,
  input  wire  [rtlfm_pkg::FPS_W-1:0]          fps_sample,
  output logic                                 done,
  output logic [rtlfm_pkg::FPS_W-1:0]          average_fps,
  output logic [rtlfm_pkg::LAT_W-1:0]          average_latency_ms,
  output logic [rtlfm_pkg::LAT_W-1:0]          measured_latency_ms,
  output logic                                 fps_updated,
  output logic                                 latency_valid
);
  import rtlfm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_STEP1 = 3'd2;
  localparam logic [2:0] S_STEP2 = 3'd3;
  localparam logic [2:0] S_STEP3 = 3'd4;

  logic [2:0]               state;
  logic [CLR_LOG2-1:0]      clr_count;
  logic                     accept;

  // Captured event
  logic                     op_q;
  logic [PEND_LOG2-1:0]     pidx_q;
  logic [LAT_HIST_LOG2-1:0] lidx_q;
  logic [TIME_W-1:0]        now_q;
  logic [FPS_W-1:0]         sample_q;

  // Working registers
  logic                     upd;
  logic [LAT_W-1:0]         measured;
  logic [SUM_W-1:0]         tmp_sum;
  logic [FPS_SUM_W-1:0]     fps_sum;
  logic [LAT_SUM_W-1:0]     lat_sum;
  logic [FPS_HIST_LOG2-1:0] fps_slot;
  logic [TIME_W-1:0]        last_fps_time;

  // Memories and their ports
  logic [FPS_W-1:0]         fps_ring   [FPS_HISTORY];
  logic [TIME_W-1:0]        send_stamp [PENDING_DEPTH];
  logic [LAT_W-1:0]         lat_ring   [LATENCY_HISTORY];

  logic [FPS_W-1:0]         fps_rdata;
  logic [TIME_W-1:0]        stamp_rdata;
  logic [LAT_W-1:0]         lat_rdata;

  logic                     fps_we;
  logic [FPS_HIST_LOG2-1:0] fps_waddr;
  logic [FPS_W-1:0]         fps_wdata;
  logic                     stamp_we;
  logic [PEND_LOG2-1:0]     stamp_waddr;
  logic [TIME_W-1:0]        stamp_wdata;
  logic                     lat_we;
  logic [LAT_HIST_LOG2-1:0] lat_waddr;
  logic [LAT_W-1:0]         lat_wdata;

  logic                     clearing;
  alu_req_t                 alu_req;
  logic [TIME_W-1:0]        alu_y;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state == S_CLEAR);

  // Averages are the running sums divided by the ring lengths (shifted down by their log2)
  assign average_fps        = fps_sum[FPS_HIST_LOG2 +: FPS_W];
  assign average_latency_ms = lat_sum[LAT_HIST_LOG2 +: LAT_W];

  // Shared adder
  rtlfm_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Select adder operands for the current step
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state)
      S_STEP1: begin
        alu_req.a = now_q;
        alu_req.b = (op_q == OP_RESPONSE) ? stamp_rdata : last_fps_time;
      end
      S_STEP2: begin
        if (op_q == OP_RESPONSE) begin
          alu_req.a = TIME_W'(lat_sum);
          alu_req.b = TIME_W'(lat_rdata);
        end else begin
          alu_req.a = TIME_W'(fps_sum);
          alu_req.b = TIME_W'(fps_rdata);
        end
      end
      S_STEP3: begin
        alu_req.sub = 1'b0;
        alu_req.a   = TIME_W'(tmp_sum);
        alu_req.b   = (op_q == OP_RESPONSE) ? TIME_W'(measured) : TIME_W'(sample_q);
      end
      default: begin
        alu_req.sub = 1'b1;
      end
    endcase
  end

  // Write ports: reset values during the clear pass, event data afterwards
  always_comb begin
    fps_we      = (clearing && ((clr_count >> FPS_HIST_LOG2) == '0)) ||
                  (state == S_STEP3 && op_q == OP_FRAME_START && upd);
    fps_waddr   = clearing ? clr_count[FPS_HIST_LOG2-1:0] : fps_slot;
    fps_wdata   = clearing ? FPS_W'(FPS_RESET) : sample_q;

    stamp_we    = (clearing && ((clr_count >> PEND_LOG2) == '0)) ||
                  (state == S_STEP1 && op_q == OP_FRAME_START);
    stamp_waddr = clearing ? clr_count[PEND_LOG2-1:0] : pidx_q;
    stamp_wdata = clearing ? '0 : now_q;

    lat_we      = (clearing && ((clr_count >> LAT_HIST_LOG2) == '0)) ||
                  (state == S_STEP3 && op_q == OP_RESPONSE);
    lat_waddr   = clearing ? clr_count[LAT_HIST_LOG2-1:0] : lidx_q;
    lat_wdata   = clearing ? LAT_W'(LATENCY_RESET_MS) : measured;
  end

  // Frame-rate ring
  always_ff @(posedge clk) begin
    if (fps_we) begin
      fps_ring[fps_waddr] <= fps_wdata;
    end
    if (accept) begin
      fps_rdata <= fps_ring[fps_slot];
    end
  end

  // Send-stamp table
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      send_stamp[stamp_waddr] <= stamp_wdata;
    end
    if (accept) begin
      stamp_rdata <= send_stamp[frame_number[PEND_LOG2-1:0]];
    end
  end

  // Latency ring
  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_ring[lat_waddr] <= lat_wdata;
    end
    if (accept) begin
      lat_rdata <= lat_ring[frame_number[LAT_HIST_LOG2-1:0]];
    end
  end

  // Capture the event on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      pidx_q   <= frame_number[PEND_LOG2-1:0];
      lidx_q   <= frame_number[LAT_HIST_LOG2-1:0];
      now_q    <= now_ms;
      sample_q <= fps_sample;
    end
  end

  // Sequencer and accumulated state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_count     <= '0;
      done          <= 1'b0;
      upd           <= 1'b0;
      fps_sum       <= FPS_SUM_W'(FPS_RESET * FPS_HISTORY);
      lat_sum       <= LAT_SUM_W'(LATENCY_RESET_MS * LATENCY_HISTORY);
      fps_slot      <= '0;
      last_fps_time <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_count <= clr_count + 1'b1;
          if (clr_count == CLR_LOG2'(CLEAR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_STEP1;
          end
        end
        S_STEP1: begin
          // Elapsed time check, or round-trip time with saturation
          upd <= (alu_y >= TIME_W'(FPS_INTERVAL_MS));
          if (alu_y[TIME_W-1:LAT_W] != '0) begin
            measured <= '1;
          end else begin
            measured <= alu_y[LAT_W-1:0];
          end
          state <= S_STEP2;
        end
        S_STEP2: begin
          // Drop the outgoing ring entry from its sum
          tmp_sum <= alu_y[SUM_W-1:0];
          state   <= S_STEP3;
        end
        S_STEP3: begin
          // Add the new entry and publish the result
          if (op_q == OP_RESPONSE) begin
            lat_sum <= alu_y[LAT_SUM_W-1:0];
          end else if (upd) begin
            fps_sum       <= alu_y[FPS_SUM_W-1:0];
            fps_slot      <= fps_slot + 1'b1;
            last_fps_time <= now_q;
          end
          measured_latency_ms <= (op_q == OP_RESPONSE) ? measured : '0;
          fps_updated         <= (op_q == OP_FRAME_START) && upd;
          latency_valid       <= (op_q == OP_RESPONSE);
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/rtlfm_alu.sv]
// Shared 32-bit add/subtract unit used by every step of the sequencer.
`default_nettype none
module rtlfm_alu (
  input  wire rtlfm_pkg::alu_req_t      req,
  output logic [rtlfm_pkg::TIME_W-1:0]  y
);
  import rtlfm_pkg::*;

  // Add or subtract modulo 2^32
  always_comb begin
    if (req.sub) begin
      y = req.a - req.b;
    end else begin
      y = req.a + req.b;
    end
  end

endmodule
`default_nettype wire

[bench/round_trip_latency_fps_monitor_tb.sv]
// Self-checking testbench for the round-trip latency and frame-rate monitor.
`timescale 1ns / 100ps
module round_trip_latency_fps_monitor_tb;
  import rtlfm_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [LAT_W-1:0] LAT_CEIL = {LAT_W{1'b1}};

  // One result as the block reports it
  typedef struct packed {
    logic [FPS_W-1:0] avg_fps;
    logic [LAT_W-1:0] avg_latency;
    logic [LAT_W-1:0] measured;
    logic             fps_upd;
    logic             lat_valid;
  } monitor_out_t;

  // One event, with an optional hand-written result
  typedef struct packed {
    logic               op;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  now;
    logic [FPS_W-1:0]   sample;
    logic               has_want;
    monitor_out_t       want;
  } stim_row_t;

  localparam monitor_out_t NO_WANT = '0;
  localparam int SCRIPT_LEN = 17;

  // Directed events: reset values, interval edge, saturation, stale and future stamps
  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    // response on a never-stamped slot right after reset
    '{OP_RESPONSE,    32'd5,          32'd100,        10'd0,     1'b1,
      '{10'd30, 16'd193, 16'd100, 1'b0, 1'b1}},
    // one millisecond short of the interval: no frame-rate update
    '{OP_FRAME_START, 32'd0,          32'd999,        10'd1023,  1'b1,
      '{10'd30, 16'd193, 16'd0, 1'b0, 1'b0}},
    // interval reached exactly: largest sample enters the ring
    '{OP_FRAME_START, 32'd0,          32'd1000,       10'd1023,  1'b1,
      '{10'd92, 16'd193, 16'd0, 1'b1, 1'b0}},
    '{OP_RESPONSE,    32'd0,          32'd1000,       10'd1023,  1'b0, NO_WANT},
    '{OP_RESPONSE,    32'd64,         32'd66535,      10'd0,     1'b0, NO_WANT},
    '{OP_RESPONSE,    32'd0,          32'd66536,      10'd0,     1'b0, NO_WANT},
    // stamp lies in the future
    '{OP_RESPONSE,    32'd0,          32'd999,        10'd0,     1'b0, NO_WANT},
    '{OP_FRAME_START, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  10'd0,     1'b0, NO_WANT},
    // round trip across the time wrap
    '{OP_RESPONSE,    32'hFFFF_FFFF,  32'h0000_0010,  10'h3FF,   1'b0, NO_WANT},
    '{OP_FRAME_START, 32'hAAAA_AAAA,  32'h0000_03E6,  10'h155,   1'b0, NO_WANT},
    '{OP_FRAME_START, 32'hAAAA_AAAA,  32'h0000_03E7,  10'h155,   1'b0, NO_WANT},
    '{OP_FRAME_START, 32'h5555_5555,  32'h5555_5555,  10'h2AA,   1'b0, NO_WANT},
    '{OP_RESPONSE,    32'h5555_5555,  32'h5555_5681,  10'h2AA,   1'b0, NO_WANT},
    '{OP_RESPONSE,    32'h0001_2345,  32'h8000_0000,  10'd0,     1'b0, NO_WANT},
    '{OP_RESPONSE,    32'd1,          32'd0,          10'd0,     1'b0, NO_WANT},
    '{OP_FRAME_START, 32'd1,          32'h7FFF_FFFF,  10'h200,   1'b0, NO_WANT},
    '{OP_RESPONSE,    32'd1,          32'h8000_0020,  10'h1FF,   1'b0, NO_WANT}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               opcode = 1'b0;
  logic [FRAME_W-1:0] frame_number = '0;
  logic [TIME_W-1:0]  now_ms = '0;
  logic [FPS_W-1:0]   fps_sample = '0;
  logic               busy;
  logic               done;
  logic [FPS_W-1:0]   average_fps;
  logic [LAT_W-1:0]   average_latency_ms;
  logic [LAT_W-1:0]   measured_latency_ms;
  logic               fps_updated;
  logic               latency_valid;

  // Predicted block state
  logic [FPS_W-1:0]         fps_hist [FPS_HISTORY];
  logic [FPS_SUM_W-1:0]     fps_total;
  logic [FPS_HIST_LOG2-1:0] fps_next;
  logic [TIME_W-1:0]        fps_last_ms;
  logic [TIME_W-1:0]        stamp_tab [PENDING_DEPTH];
  logic [LAT_W-1:0]         lat_hist [LATENCY_HISTORY];
  logic [LAT_SUM_W-1:0]     lat_total;

  monitor_out_t awaited_averages [$];
  int unsigned  mismatch_count = 0;
  int           burst_left = 0;

  round_trip_latency_fps_monitor dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .opcode              (opcode),
    .frame_number        (frame_number),
    .now_ms              (now_ms),
    .fps_sample          (fps_sample),
    .done                (done),
    .average_fps         (average_fps),
    .average_latency_ms  (average_latency_ms),
    .measured_latency_ms (measured_latency_ms),
    .fps_updated         (fps_updated),
    .latency_valid       (latency_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one event to the predicted state and return the averages it yields
  function automatic monitor_out_t track_event(input logic op, input logic [FRAME_W-1:0] fr,
                                               input logic [TIME_W-1:0] now,
                                               input logic [FPS_W-1:0] smp);
    monitor_out_t             r;
    logic [TIME_W-1:0]        diff;
    logic [PEND_LOG2-1:0]     pidx;
    logic [LAT_HIST_LOG2-1:0] lidx;
    logic [LAT_W-1:0]         meas;
    r = '0;
    pidx = fr[PEND_LOG2-1:0];
    if (op == OP_FRAME_START) begin
      diff = now - fps_last_ms;
      if (diff >= TIME_W'(FPS_INTERVAL_MS)) begin
        fps_total = fps_total - FPS_SUM_W'(fps_hist[fps_next]) + FPS_SUM_W'(smp);
        fps_hist[fps_next] = smp;
        fps_next = fps_next + 1'b1;
        fps_last_ms = now;
        r.fps_upd = 1'b1;
      end
      stamp_tab[pidx] = now;
    end else begin
      diff = now - stamp_tab[pidx];
      meas = (diff > TIME_W'(LAT_CEIL)) ? LAT_CEIL : diff[LAT_W-1:0];
      lidx = fr[LAT_HIST_LOG2-1:0];
      lat_total = lat_total - LAT_SUM_W'(lat_hist[lidx]) + LAT_SUM_W'(meas);
      lat_hist[lidx] = meas;
      r.measured = meas;
      r.lat_valid = 1'b1;
    end
    r.avg_fps = FPS_W'(fps_total >> FPS_HIST_LOG2);
    r.avg_latency = LAT_W'(lat_total >> LAT_HIST_LOG2);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // Hold the sender idle between bursts of back-to-back events
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Offer one event and wait for its transfer, then queue its result
  task automatic drive_event(input stim_row_t row);
    monitor_out_t guess;
    start        <= 1'b1;
    opcode       <= row.op;
    frame_number <= row.frame;
    now_ms       <= row.now;
    fps_sample   <= row.sample;
    do @(posedge clk); while (busy);
    guess = track_event(row.op, row.frame, row.now, row.sample);
    awaited_averages.push_back(row.has_want ? row.want : guess);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    monitor_out_t want;
    if (!rst && done) begin
      if (awaited_averages.size() == 0) begin
        flag_mismatch("result with nothing expected", 0, 1);
      end else begin
        want = awaited_averages.pop_front();
        if (average_fps !== want.avg_fps)
          flag_mismatch("average_fps", want.avg_fps, average_fps);
        if (average_latency_ms !== want.avg_latency)
          flag_mismatch("average_latency_ms", want.avg_latency, average_latency_ms);
        if (measured_latency_ms !== want.measured)
          flag_mismatch("measured_latency_ms", want.measured, measured_latency_ms);
        if (fps_updated !== want.fps_upd)
          flag_mismatch("fps_updated", want.fps_upd, fps_updated);
        if (latency_valid !== want.lat_valid)
          flag_mismatch("latency_valid", want.lat_valid, latency_valid);
      end
    end
  end

  initial begin
    stim_row_t          row;
    logic [TIME_W-1:0]  game_ms;
    logic [FRAME_W-1:0] next_frame;
    logic [FRAME_W-1:0] frames_sent [$];
    int unsigned        pick;
    int unsigned        reach;

    // Start the predicted state from its reset values
    foreach (fps_hist[i]) fps_hist[i] = FPS_W'(FPS_RESET);
    foreach (stamp_tab[i]) stamp_tab[i] = '0;
    foreach (lat_hist[i]) lat_hist[i] = LAT_W'(LATENCY_RESET_MS);
    fps_total   = FPS_SUM_W'(FPS_RESET * FPS_HISTORY);
    lat_total   = LAT_SUM_W'(LATENCY_RESET_MS * LATENCY_HISTORY);
    fps_next    = '0;
    fps_last_ms = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed events
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      pace_sender();
      drive_event(SCRIPT[i]);
    end

    // Mostly frame/response traffic from a running game, with some noise
    game_ms    = $urandom;
    next_frame = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8)
        game_ms = game_ms + $urandom_range(900, 2500);
      else
        game_ms = game_ms + $urandom_range(0, 40);
      row = '0;
      row.now = game_ms;
      row.sample = ($urandom_range(0, 1)) ? FPS_W'($urandom_range(20, 144)) :
                                            FPS_W'($urandom_range(0, 1023));
      if (pick < 45) begin
        row.op = OP_FRAME_START;
        row.frame = next_frame;
        frames_sent.push_back(next_frame);
        if (frames_sent.size() > 96) void'(frames_sent.pop_front());
        next_frame = next_frame + 1'b1;
      end else if (pick < 88 && frames_sent.size() > 0) begin
        row.op = OP_RESPONSE;
        // mostly recent frames; now and then one whose slot was reused
        reach = ($urandom_range(0, 9) == 0) ? frames_sent.size() - 1 :
                ((frames_sent.size() > 16) ? 15 : frames_sent.size() - 1);
        row.frame = frames_sent[frames_sent.size() - 1 - $urandom_range(0, reach)];
      end else begin
        row.op = $urandom_range(0, 1) ? OP_RESPONSE : OP_FRAME_START;
        row.frame = $urandom;
        row.now = $urandom;
        row.sample = FPS_W'($urandom_range(0, 1023));
      end
      pace_sender();
      drive_event(row);
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (awaited_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
